FILE: hw/rtl/rbmm_pkg.sv
package rbmm_pkg;

    // pipeline shape
    localparam int CORDIC_STEPS = 30;
    localparam int ROOT_BITS    = 32;
    localparam int QD_STEPS     = 16;
    localparam int QD2_STEPS    = 32;

    localparam logic [16:0] MIN_DIST_RESET = 17'd1;

    // CORDIC datapath word, headroom for the vectoring gain
    typedef logic signed [34:0] cordic_t;

    // magnitudes and signs of the position differences, index 0 = x, 1 = y
    typedef struct packed {
        logic [1:0][30:0] mag;
        logic [1:0]       neg;
    } diff_side_t;

    // atan(2^-i) in turn units, 2^32 = one full turn
    function automatic logic [31:0] atan_turn(input int step);
        logic [31:0] val;
        case (step)
            0:  val = 32'd536870912;
            1:  val = 32'd316933406;
            2:  val = 32'd167458907;
            3:  val = 32'd85004756;
            4:  val = 32'd42667331;
            5:  val = 32'd21354465;
            6:  val = 32'd10679838;
            7:  val = 32'd5340245;
            8:  val = 32'd2670163;
            9:  val = 32'd1335087;
            10: val = 32'd667544;
            11: val = 32'd333772;
            12: val = 32'd166886;
            13: val = 32'd83443;
            14: val = 32'd41722;
            15: val = 32'd20861;
            16: val = 32'd10430;
            17: val = 32'd5215;
            18: val = 32'd2608;
            19: val = 32'd1304;
            20: val = 32'd652;
            21: val = 32'd326;
            22: val = 32'd163;
            23: val = 32'd81;
            24: val = 32'd41;
            25: val = 32'd20;
            26: val = 32'd10;
            27: val = 32'd5;
            28: val = 32'd3;
            29: val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

FILE: hw/rtl/range_bearing_measurement_model.sv
// Range / bearing measurement model with Jacobian quotients.
// Slave stream: one beat carries an ego pose and a measured agent position.
// Master stream: one beat carries range, bearing, dx/d, dy/d, dy/d^2, dx/d^2
// and a saturation flag for the squared-distance quotients.
// cfg_wr_en / cfg_wr_data write the distance clamp (Q16.16, 0 acts as 1);
// write it only while no beat is in flight.
// Throughput: one beat per cycle while not stalled. The path is a 72-stage
// pipeline: 4 prep stages, a 32-stage bit-per-stage square root, clamp and a
// 32x32 squaring multiply, then 33 restoring division stages (an overflow
// check, then one quotient bit each) and the output register; the 30-step
// CORDIC runs beside the square root.
// Stall: when m_tready is low with a beat waiting, the whole pipeline holds
// and s_tready drops in the same cycle; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and sets the
// distance clamp back to 1.
module range_bearing_measurement_model (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [16:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ego_x[30:0], ego_y[61:31], ego_heading[77:62], agent_x[108:78],
    // agent_y[139:109], zero fill [143:140]
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // predicted_range[31:0], predicted_bearing[47:32], dx_over_dist[65:48],
    // dy_over_dist[83:66], dy_over_dist_sq[115:84], dx_over_dist_sq[147:116],
    // saturated[148], zero fill [151:149]
    output logic [151:0] m_tdata
);
    import rbmm_pkg::*;

    logic         pipe_en;
    logic [70:0]  vld_reg;
    logic         m_tvalid_reg;
    logic [151:0] m_tdata_reg;
    logic [16:0]  min_dist_reg;
    logic [16:0]  dist_floor;

    // global advance: hold everything while a result waits
    assign pipe_en  = !m_tvalid_reg || m_tready;
    assign s_tready = pipe_en && aresetn;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign dist_floor = (min_dist_reg == 17'd0) ? 17'd1 : min_dist_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            min_dist_reg <= MIN_DIST_RESET;
        end else begin
            if (cfg_wr_en) begin
                min_dist_reg <= cfg_wr_data;
            end
            if (pipe_en) begin
                vld_reg      <= {vld_reg[69:0], s_tvalid};
                m_tvalid_reg <= vld_reg[70];
            end
        end
    end

    // stage 0: differences
    logic signed [31:0] ego_x_s, ego_y_s, agent_x_s, agent_y_s;
    logic signed [31:0] dx0_reg, dy0_reg;
    logic [15:0]        hd0_reg;

    always_comb begin
        ego_x_s   = {s_tdata[30],  s_tdata[30:0]};
        ego_y_s   = {s_tdata[61],  s_tdata[61:31]};
        agent_x_s = {s_tdata[108], s_tdata[108:78]};
        agent_y_s = {s_tdata[139], s_tdata[139:109]};
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            dx0_reg <= agent_x_s - ego_x_s;
            dy0_reg <= agent_y_s - ego_y_s;
            hd0_reg <= s_tdata[77:62];
        end
    end

    // stage 1: magnitudes, half-turn fold for CORDIC
    logic [31:0]        abs_x, abs_y;
    logic signed [31:0] cy_fold;
    diff_side_t         side1_reg;
    logic [30:0]        cx1_reg;
    logic signed [31:0] cy1_reg;
    logic               xneg1_reg, zero1_reg;
    logic [15:0]        hd1_reg;

    always_comb begin
        abs_x   = dx0_reg[31] ? 32'(-dx0_reg) : 32'(dx0_reg);
        abs_y   = dy0_reg[31] ? 32'(-dy0_reg) : 32'(dy0_reg);
        cy_fold = dx0_reg[31] ? -dy0_reg : dy0_reg;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            side1_reg.mag[0] <= abs_x[30:0];
            side1_reg.mag[1] <= abs_y[30:0];
            side1_reg.neg    <= {dy0_reg[31], dx0_reg[31]};
            cx1_reg          <= abs_x[30:0];
            cy1_reg          <= cy_fold;
            xneg1_reg        <= dx0_reg[31];
            zero1_reg        <= (dx0_reg == 32'sd0) && (dy0_reg == 32'sd0);
            hd1_reg          <= hd0_reg;
        end
    end

    // stage 2: squares; normalize shift count
    logic [61:0] sqx2_reg, sqy2_reg;
    diff_side_t  side2_reg;
    logic [31:0] cy_abs;
    logic [30:0] norm_or;
    logic [4:0]  msb_pos;
    logic [4:0]  k2_reg;
    logic [30:0] cx2_reg;
    logic signed [31:0] cy2_reg;
    logic        xneg2_reg, zero2_reg;
    logic [15:0] hd2_reg;

    always_comb begin
        cy_abs  = cy1_reg[31] ? 32'(-cy1_reg) : 32'(cy1_reg);
        norm_or = cx1_reg | cy_abs[30:0];
        msb_pos = 5'd0;
        for (int j = 0; j < 31; j++) begin
            if (norm_or[j]) begin
                msb_pos = 5'(j);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sqx2_reg  <= {31'b0, side1_reg.mag[0]} * {31'b0, side1_reg.mag[0]};
            sqy2_reg  <= {31'b0, side1_reg.mag[1]} * {31'b0, side1_reg.mag[1]};
            side2_reg <= side1_reg;
            k2_reg    <= 5'd30 - msb_pos;
            cx2_reg   <= cx1_reg;
            cy2_reg   <= cy1_reg;
            xneg2_reg <= xneg1_reg;
            zero2_reg <= zero1_reg;
            hd2_reg   <= hd1_reg;
        end
    end

    // stage 3: sum of squares; normalized CORDIC operands
    logic [63:0]  sq_rem_reg  [0:32];
    logic [31:0]  sq_root_reg [0:32];
    diff_side_t   sq_side_reg [0:32];
    cordic_t      cx_reg   [0:30];
    cordic_t      cy_reg   [0:30];
    logic [31:0]  cz_reg   [0:30];
    logic         czero_reg[0:30];
    logic [15:0]  chd_reg  [0:30];
    cordic_t      x_norm, y_norm;

    always_comb begin
        x_norm = cordic_t'({4'b0, cx2_reg}) << k2_reg;
        y_norm = cordic_t'({{3{cy2_reg[31]}}, cy2_reg}) << k2_reg;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sq_rem_reg[0]  <= {2'b0, sqx2_reg} + {2'b0, sqy2_reg};
            sq_root_reg[0] <= '0;
            sq_side_reg[0] <= side2_reg;
            cx_reg[0]      <= x_norm;
            cy_reg[0]      <= y_norm;
            cz_reg[0]      <= {xneg2_reg, 31'b0};
            czero_reg[0]   <= zero2_reg;
            chd_reg[0]     <= hd2_reg;
        end
    end

    // CORDIC vectoring, one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        cordic_t     xs, ys, x_next, y_next;
        logic [31:0] z_next;

        always_comb begin
            xs = cx_reg[i] >>> i;
            ys = cy_reg[i] >>> i;
            if (!cy_reg[i][34]) begin
                x_next = cx_reg[i] + ys;
                y_next = cy_reg[i] - xs;
                z_next = cz_reg[i] + atan_turn(i);
            end else begin
                x_next = cx_reg[i] - ys;
                y_next = cy_reg[i] + xs;
                z_next = cz_reg[i] - atan_turn(i);
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                cx_reg[i+1]    <= x_next;
                cy_reg[i+1]    <= y_next;
                cz_reg[i+1]    <= z_next;
                czero_reg[i+1] <= czero_reg[i];
                chd_reg[i+1]   <= chd_reg[i];
            end
        end
    end

    // stage 34: bearing relative to heading, rounded to 16 bits
    logic [15:0] bearing_reg [34:70];
    logic [31:0] z_fin, rel_turn;

    always_comb begin
        z_fin    = czero_reg[30] ? 32'd0 : cz_reg[30];
        rel_turn = z_fin - {chd_reg[30], 16'h0000} + 32'h0000_8000;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            bearing_reg[34] <= rel_turn[31:16];
        end
    end

    for (genvar p = 35; p <= 70; p++) begin : g_bearing_dly
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                bearing_reg[p] <= bearing_reg[p-1];
            end
        end
    end

    // square root, one result bit per stage, MSB first
    for (genvar j = 0; j < ROOT_BITS; j++) begin : g_sqrt
        localparam int BIT = ROOT_BITS - 1 - j;
        logic [65:0] trial, rem_ext;
        logic [63:0] rem_next;
        logic [31:0] root_next;

        always_comb begin
            trial   = ({34'b0, sq_root_reg[j]} << (BIT + 1)) + (66'd1 << (2 * BIT));
            rem_ext = {2'b0, sq_rem_reg[j]};
            if (rem_ext >= trial) begin
                rem_next  = 64'(rem_ext - trial);
                root_next = sq_root_reg[j] | (32'd1 << BIT);
            end else begin
                rem_next  = sq_rem_reg[j];
                root_next = sq_root_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                sq_rem_reg[j+1]  <= rem_next;
                sq_root_reg[j+1] <= root_next;
                sq_side_reg[j+1] <= sq_side_reg[j];
            end
        end
    end

    // stages 36-37: clamp and square the divisor
    logic [31:0] range_reg [36:70];
    logic [31:0] dc36_reg, dc37_reg;
    logic [63:0] dc2_37_reg;
    diff_side_t  side36_reg, side37_reg;
    logic [31:0] floor_ext;

    assign floor_ext = {15'b0, dist_floor};

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            range_reg[36] <= sq_root_reg[32];
            dc36_reg      <= (sq_root_reg[32] < floor_ext) ? floor_ext : sq_root_reg[32];
            side36_reg    <= sq_side_reg[32];
            dc37_reg      <= dc36_reg;
            dc2_37_reg    <= {32'b0, dc36_reg} * {32'b0, dc36_reg};
            side37_reg    <= side36_reg;
        end
    end

    for (genvar p = 37; p <= 70; p++) begin : g_range_dly
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                range_reg[p] <= range_reg[p-1];
            end
        end
    end

    // quotient over distance: 17-bit restoring division
    logic [31:0] qd_r_reg  [0:16][2];
    logic [16:0] qd_q_reg  [0:16][2];
    logic [31:0] qd_dc_reg [0:16];
    logic [17:0] qd_fin_reg[55:70][2];

    // quotient over squared distance: overflow check plus 32 quotient bits
    logic [63:0] qs_r_reg  [0:32][2];
    logic [31:0] qs_q_reg  [0:32][2];
    logic        qs_ovf_reg[0:32][2];
    logic [63:0] qs_dc2_reg[0:32];
    logic [1:0]  qs_neg_reg[0:32];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            qd_dc_reg[0]  <= dc37_reg;
            qs_dc2_reg[0] <= dc2_37_reg;
            qs_neg_reg[0] <= side37_reg.neg;
        end
    end

    for (genvar a = 0; a < 2; a++) begin : g_axis
        logic [32:0] mag33;
        logic [63:0] mag64;
        logic        top_ge;

        // first step of both divisions
        always_comb begin
            mag33  = {2'b0, side37_reg.mag[a]};
            mag64  = {33'b0, side37_reg.mag[a]};
            top_ge = mag33 >= {1'b0, dc37_reg};
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                qd_r_reg[0][a]   <= top_ge ? 32'(mag33 - {1'b0, dc37_reg}) : mag33[31:0];
                qd_q_reg[0][a]   <= {top_ge, 16'b0};
                qs_r_reg[0][a]   <= mag64;
                qs_q_reg[0][a]   <= '0;
                qs_ovf_reg[0][a] <= mag64 >= dc2_37_reg;
            end
        end

        for (genvar s = 1; s <= QD_STEPS; s++) begin : g_qd
            logic [32:0] r2;
            logic        ge;
            logic [31:0] r_next;

            always_comb begin
                r2     = {qd_r_reg[s-1][a], 1'b0};
                ge     = r2 >= {1'b0, qd_dc_reg[s-1]};
                r_next = ge ? 32'(r2 - {1'b0, qd_dc_reg[s-1]}) : r2[31:0];
            end

            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    qd_r_reg[s][a] <= r_next;
                    qd_q_reg[s][a] <= qd_q_reg[s-1][a] | (17'(ge) << (QD_STEPS - s));
                end
            end
        end

        // signed Q1.16 result
        logic [17:0] qd_mag;
        assign qd_mag = {1'b0, qd_q_reg[QD_STEPS][a]};

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                qd_fin_reg[55][a] <= qs_neg_reg[QD_STEPS][a] ? 18'(-qd_mag) : qd_mag;
            end
        end

        for (genvar p = 56; p <= 70; p++) begin : g_qd_dly
            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    qd_fin_reg[p][a] <= qd_fin_reg[p-1][a];
                end
            end
        end

        for (genvar s = 1; s <= QD2_STEPS; s++) begin : g_qs
            logic [64:0] r2;
            logic        ge;
            logic [63:0] r_next;

            always_comb begin
                r2     = {qs_r_reg[s-1][a], 1'b0};
                ge     = r2 >= {1'b0, qs_dc2_reg[s-1]};
                r_next = ge ? 64'(r2 - {1'b0, qs_dc2_reg[s-1]}) : r2[63:0];
            end

            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    qs_r_reg[s][a]   <= r_next;
                    qs_q_reg[s][a]   <= qs_q_reg[s-1][a] | (32'(ge) << (QD2_STEPS - s));
                    qs_ovf_reg[s][a] <= qs_ovf_reg[s-1][a];
                end
            end
        end
    end

    for (genvar s = 1; s <= QD2_STEPS; s++) begin : g_qs_side
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                qs_dc2_reg[s] <= qs_dc2_reg[s-1];
                qs_neg_reg[s] <= qs_neg_reg[s-1];
            end
        end
    end

    for (genvar s = 1; s <= QD_STEPS; s++) begin : g_qd_side
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                qd_dc_reg[s] <= qd_dc_reg[s-1];
            end
        end
    end

    // output stage: sign and saturate the squared-distance quotients
    logic [1:0][31:0] sq_val;
    logic [1:0]       sq_sat;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            if (qs_neg_reg[QD2_STEPS][a]) begin
                sq_sat[a] = qs_ovf_reg[QD2_STEPS][a] ||
                            (qs_q_reg[QD2_STEPS][a][31] && (qs_q_reg[QD2_STEPS][a][30:0] != '0));
                sq_val[a] = sq_sat[a] ? 32'h8000_0000 : 32'(-qs_q_reg[QD2_STEPS][a]);
            end else begin
                sq_sat[a] = qs_ovf_reg[QD2_STEPS][a] || qs_q_reg[QD2_STEPS][a][31];
                sq_val[a] = sq_sat[a] ? 32'h7FFF_FFFF : qs_q_reg[QD2_STEPS][a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_tdata_reg <= {3'b0, |sq_sat, sq_val[0], sq_val[1],
                            qd_fin_reg[70][1], qd_fin_reg[70][0],
                            bearing_reg[70], range_reg[70]};
        end
    end

`ifndef SYNTHESIS
    // distance quotients can never exceed one in magnitude
    a_unit_quot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (($signed(m_tdata[65:48]) <= 18'sd65536) &&
                      ($signed(m_tdata[65:48]) >= -18'sd65536) &&
                      ($signed(m_tdata[83:66]) <= 18'sd65536) &&
                      ($signed(m_tdata[83:66]) >= -18'sd65536)))
        else $error("distance quotient out of range");

    // a saturation flag means one quotient sits at a rail
    a_sat_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[148]) |->
            ((m_tdata[115:84] == 32'h7FFF_FFFF) || (m_tdata[115:84] == 32'h8000_0000) ||
             (m_tdata[147:116] == 32'h7FFF_FFFF) || (m_tdata[147:116] == 32'h8000_0000)))
        else $error("saturated flag without a railed quotient");

    // reset empties the pipeline
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && (vld_reg == '0)))
        else $error("beats survive reset");
`endif

endmodule
